// File: hdl/mpps_pkg.sv
`timescale 1ns / 1ps
package mpps_pkg;

    localparam int NUM_PORTS   = 3;
    localparam int PORT_W      = 2;
    localparam int BYTE_W      = 8;
    localparam int PROTO_W     = 3;
    localparam int ACTIVE_W    = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        ACT_DATA    = 2'd0,
        ACT_CONFIRM = 2'd1,
        ACT_ERROR   = 2'd2,
        ACT_RELEASE = 2'd3
    } t_action;

    // classified request passed from the front end to the back end
    typedef struct packed {
        t_action                 action;
        logic [PORT_W-1:0]       port;
        logic [BYTE_W-1:0]       data_byte;
    } t_req;

    typedef struct packed {
        logic [ACTIVE_W-1:0]     active_ports;
        logic [PORT_W-1:0]       priority_port;
        logic                    priority_valid;
        logic [PROTO_W-1:0]      radio_protocol;
        logic                    port_locked;
        logic [PROTO_W-1:0]      port_protocol;
    } t_result;

endpackage

// File: hdl/mpps_front.sv
`timescale 1ns / 1ps
module mpps_front #(
    parameter int PORTS = mpps_pkg::NUM_PORTS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_action,
    input  logic [mpps_pkg::PORT_W-1:0] i_port,
    input  logic [mpps_pkg::BYTE_W-1:0] i_data_byte,
    output logic                       o_valid,
    input  logic                       i_ready,
    output mpps_pkg::t_req             o_req
);
    import mpps_pkg::*;

    localparam int CMP_W = PORT_W + 1;

    logic r_vld;
    t_req r_req;
    t_req n_req;

    // out-of-range ports fold onto port 0
    always_comb begin
        n_req.action    = t_action'(i_action);
        n_req.data_byte = i_data_byte;
        if ({1'b0, i_port} >= CMP_W'(PORTS)) begin
            n_req.port = '0;
        end else begin
            n_req.port = i_port;
        end
    end

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_req <= n_req;
        end
    end

endmodule

// File: hdl/mpps_queue.sv
`timescale 1ns / 1ps
module mpps_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mpps_pkg::t_req i_req,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output mpps_pkg::t_req o_req
);
    import mpps_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_req             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_ready = (r_cnt != CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_req   = r_mem[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (do_push) begin
            r_mem[r_wptr] <= i_req;
        end
    end

endmodule

// File: hdl/mpps_back.sv
`timescale 1ns / 1ps
module mpps_back #(
    parameter int PORTS = mpps_pkg::NUM_PORTS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mpps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mpps_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_valid,
    output logic                            o_pop,
    input  mpps_pkg::t_req                  i_req,
    output logic                            o_valid,
    input  logic                            i_ready,
    output mpps_pkg::t_result               o_result
);
    import mpps_pkg::*;

    localparam logic [PROTO_W-1:0] PR_UNKNOWN = 3'd0;
    localparam logic [PROTO_W-1:0] PR_MESH_A  = 3'd1;
    localparam logic [PROTO_W-1:0] PR_MESH_B  = 3'd2;
    localparam logic [PROTO_W-1:0] PR_KISS    = 3'd3;
    localparam logic [PROTO_W-1:0] PR_AT      = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_MESH_A_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MESH_A_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MESH_B_FIRST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MESH_B_SECOND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_END     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_TIMEOUT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LOCK_LIMIT    = 3'd6;

    localparam logic [BYTE_W-1:0] CHAR_A = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_T = 8'h54;
    localparam int PAD_W = (PORTS > ACTIVE_W) ? PORTS : ACTIVE_W;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_MESH_A = 2'd1,
        PH_MESH_B = 2'd2,
        PH_AT     = 2'd3
    } t_phase;

    // configuration
    logic [BYTE_W-1:0] r_a_first, r_a_second, r_b_first, r_b_second, r_frame_end;
    logic [15:0]       r_timeout;
    logic [BYTE_W-1:0] r_limit;

    // per-port detector state
    t_phase             r_phase  [PORTS];
    logic [PROTO_W-1:0] r_found  [PORTS];
    logic [7:0]         r_lock   [PORTS];
    logic [15:0]        r_pbytes [PORTS];
    logic [PORTS-1:0]   r_active;

    // radio arbiter
    logic [PROTO_W-1:0] r_own_proto;
    logic               r_own_vld;
    logic [PORT_W-1:0]  r_own_port;

    logic    r_out_vld;
    t_result r_out;

    t_phase             n_phase, ph_det;
    logic [PROTO_W-1:0] n_found, hit;
    logic [7:0]         n_lock;
    logic [15:0]        n_pbytes;
    logic [PORTS-1:0]   n_active;
    logic [PROTO_W-1:0] n_own_proto;
    logic               n_own_vld;
    logic [PORT_W-1:0]  n_own_port;
    logic               det, locked, can;
    logic [PAD_W-1:0]   act_pad;
    t_result            n_out;
    logic [PORT_W-1:0]  p;
    logic [BYTE_W-1:0]  b;

    assign o_pop    = i_valid && (!r_out_vld || i_ready);
    assign o_valid  = r_out_vld;
    assign o_result = r_out;
    assign p        = i_req.port;
    assign b        = i_req.data_byte;

    always_comb begin
        n_phase     = r_phase[p];
        n_found     = r_found[p];
        n_lock      = r_lock[p];
        n_pbytes    = r_pbytes[p];
        n_active    = r_active;
        n_own_proto = r_own_proto;
        n_own_vld   = r_own_vld;
        n_own_port  = r_own_port;
        det         = 1'b0;
        hit         = r_found[p];
        ph_det      = PH_IDLE;
        locked      = (r_lock[p] >= r_limit);
        can         = 1'b0;

        unique case (i_req.action)
            ACT_DATA: begin
                n_active[p] = 1'b1;
                if (n_pbytes != 16'hFFFF) begin
                    n_pbytes = n_pbytes + 16'd1;
                end
                if (n_phase != PH_IDLE && n_pbytes > r_timeout) begin
                    n_phase  = PH_IDLE;
                    n_pbytes = '0;
                end
                if (locked) begin
                    det = 1'b1;
                    hit = n_found;
                end else begin
                    ph_det = n_phase;
                    unique case (n_phase)
                        PH_IDLE: begin
                            // first match wins, even if it then does nothing
                            if (b == r_a_first) begin
                                ph_det = PH_MESH_A;
                            end else if (b == r_b_first) begin
                                ph_det = PH_MESH_B;
                            end else if (b == r_frame_end) begin
                                if (n_found == PR_UNKNOWN || n_found == PR_KISS) begin
                                    n_found = PR_KISS;
                                    det     = 1'b1;
                                end
                            end else if (b == CHAR_A) begin
                                ph_det = PH_AT;
                            end
                        end
                        PH_MESH_A: begin
                            if (b == r_a_second) begin
                                n_found = PR_MESH_A;
                                ph_det  = PH_IDLE;
                                det     = 1'b1;
                            end else if (b != r_a_first) begin
                                ph_det = PH_IDLE;
                            end
                        end
                        PH_MESH_B: begin
                            ph_det = PH_IDLE;
                            if (b == r_b_second) begin
                                n_found = PR_MESH_B;
                                det     = 1'b1;
                            end
                        end
                        default: begin
                            ph_det = PH_IDLE;
                            if (b == CHAR_T) begin
                                n_found = PR_AT;
                                det     = 1'b1;
                            end
                        end
                    endcase
                    hit = n_found;
                    // completed detection keeps the byte count
                    if (!det && ph_det != n_phase) begin
                        n_pbytes = '0;
                    end
                    n_phase = ph_det;
                end
                if (det) begin
                    can = !r_own_vld || r_own_port == p || r_own_proto == hit;
                    if (can) begin
                        if (r_own_proto == PR_UNKNOWN || r_own_proto == hit) begin
                            n_own_proto = hit;
                        end
                        if (!r_own_vld && locked) begin
                            n_own_vld  = 1'b1;
                            n_own_port = p;
                        end
                    end
                end
            end
            ACT_CONFIRM: begin
                if (n_lock != 8'hFF) begin
                    n_lock = n_lock + 8'd1;
                end
            end
            ACT_ERROR: begin
                n_lock = (n_lock > 8'd2) ? n_lock - 8'd2 : 8'd0;
                if (n_lock == 8'd0) begin
                    n_found = PR_UNKNOWN;
                end
            end
            default: begin
                if (r_own_vld && r_own_port == p) begin
                    n_own_vld  = 1'b0;
                    n_own_port = '0;
                end
                n_phase     = PH_IDLE;
                n_found     = PR_UNKNOWN;
                n_lock      = '0;
                n_pbytes    = '0;
                n_active[p] = 1'b0;
            end
        endcase

        act_pad              = PAD_W'(n_active);
        n_out.port_protocol  = n_found;
        n_out.port_locked    = (n_lock >= r_limit);
        n_out.radio_protocol = n_own_proto;
        n_out.priority_valid = n_own_vld;
        n_out.priority_port  = n_own_vld ? n_own_port : '0;
        n_out.active_ports   = act_pad[ACTIVE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_first   <= 8'd60;
            r_a_second  <= 8'd62;
            r_b_first   <= 8'd148;
            r_b_second  <= 8'd195;
            r_frame_end <= 8'd192;
            r_timeout   <= 16'd64;
            r_limit     <= 8'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MESH_A_FIRST:  r_a_first   <= i_cfg_wdata[BYTE_W-1:0];
                REG_MESH_A_SECOND: r_a_second  <= i_cfg_wdata[BYTE_W-1:0];
                REG_MESH_B_FIRST:  r_b_first   <= i_cfg_wdata[BYTE_W-1:0];
                REG_MESH_B_SECOND: r_b_second  <= i_cfg_wdata[BYTE_W-1:0];
                REG_FRAME_END:     r_frame_end <= i_cfg_wdata[BYTE_W-1:0];
                REG_SYNC_TIMEOUT:  r_timeout   <= i_cfg_wdata[15:0];
                REG_LOCK_LIMIT:    r_limit     <= i_cfg_wdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < PORTS; q++) begin
                r_phase[q]  <= PH_IDLE;
                r_found[q]  <= PR_UNKNOWN;
                r_lock[q]   <= '0;
                r_pbytes[q] <= '0;
            end
            r_active    <= '0;
            r_own_proto <= PR_UNKNOWN;
            r_own_vld   <= 1'b0;
            r_own_port  <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase[p]  <= n_phase;
                r_found[p]  <= n_found;
                r_lock[p]   <= n_lock;
                r_pbytes[p] <= n_pbytes;
                r_active    <= n_active;
                r_own_proto <= n_own_proto;
                r_own_vld   <= n_own_vld;
                r_own_port  <= n_own_port;
                r_out_vld   <= 1'b1;
            end else if (i_ready) begin
                r_out_vld   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

endmodule

// File: hdl/multi_port_protocol_sniffer_top.sv
`timescale 1ns / 1ps
// Protocol sniffer for three byte-stream ports. Each request names a
// port and either carries a received byte or a frame confirm / frame error /
// radio release event, and produces exactly one result: the port's detected
// protocol and lock state plus the shared radio owner, priority port and the
// per-port activity mask. Requests pass through an input register, a
// two-entry queue and an update unit that owns all detector and arbiter
// state, so one request per clock is sustained while the output is not
// stalled; a request is held in the input register, then in the queue,
// and its result is registered in the update unit for the master side.
// Configuration registers take effect on the next request and should only be
// written while no request is in flight.
module multi_port_protocol_sniffer_top #(
    parameter int PORTS = mpps_pkg::NUM_PORTS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mpps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mpps_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [7:0]                      i_s_tdata,   // [7:0] data_byte
    input  logic [3:0]                      i_s_tuser,   // [1:0] action, [3:2] port
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [2:0] port_protocol, [3] port_locked, [6:4] radio_protocol,
    // [7] priority_valid, [9:8] priority_port, [12:10] active_ports
    output logic [15:0]                     o_m_tdata
);
    import mpps_pkg::*;

    logic    fr_valid, q_ready, q_valid, q_pop;
    t_req    fr_req, q_req;
    t_result res;

    mpps_front #(.PORTS(PORTS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_action    (i_s_tuser[1:0]),
        .i_port      (i_s_tuser[3:2]),
        .i_data_byte (i_s_tdata),
        .o_valid     (fr_valid),
        .i_ready     (q_ready),
        .o_req       (fr_req)
    );

    mpps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_valid),
        .i_req   (fr_req),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_req   (q_req)
    );

    mpps_back #(.PORTS(PORTS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (q_valid),
        .o_pop       (q_pop),
        .i_req       (q_req),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_result    (res)
    );

    assign o_m_tdata = {3'b000, res};

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import mpps_pkg::*;

    localparam logic [2:0] PROTO_UNKNOWN = 3'd0;
    localparam logic [2:0] PROTO_MESH_A  = 3'd1;
    localparam logic [2:0] PROTO_MESH_B  = 3'd2;
    localparam logic [2:0] PROTO_KISS    = 3'd3;
    localparam logic [2:0] PROTO_AT      = 3'd4;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_MESH_A = 2'd1;
    localparam logic [1:0] PH_MESH_B = 2'd2;
    localparam logic [1:0] PH_AT     = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MESH_A_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MESH_A_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MESH_B_FIRST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MESH_B_SECOND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_END     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_TIMEOUT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LOCK_LIMIT    = 3'd6;

    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_T = 8'h54;
    localparam logic [7:0] LOCK_MAX = 8'd255;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 8;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [7:0]            i_s_tdata = '0;   // [7:0] data_byte
    logic [3:0]            i_s_tuser = '0;   // [1:0] action, [3:2] port
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    // [2:0] port_protocol, [3] port_locked, [6:4] radio_protocol,
    // [7] priority_valid, [9:8] priority_port, [12:10] active_ports
    logic [15:0]           o_m_tdata;

    multi_port_protocol_sniffer_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // sniffer state mirrored by the predictor
    logic [7:0]  mesh_a_first = 8'd60;
    logic [7:0]  mesh_a_second = 8'd62;
    logic [7:0]  mesh_b_first = 8'd148;
    logic [7:0]  mesh_b_second = 8'd195;
    logic [7:0]  fend_byte = 8'd192;
    logic [15:0] sync_limit = 16'd64;
    logic [7:0]  lock_level = 8'd3;

    logic [1:0]  phase     [NUM_PORTS] = '{default: PH_IDLE};
    logic [2:0]  found     [NUM_PORTS] = '{default: PROTO_UNKNOWN};
    logic [7:0]  lock_cnt  [NUM_PORTS] = '{default: 8'd0};
    logic [15:0] phase_cnt [NUM_PORTS] = '{default: 16'd0};
    logic        seen      [NUM_PORTS] = '{default: 1'b0};
    logic [2:0]  radio_owner = PROTO_UNKNOWN;
    logic        prio_valid = 1'b0;
    logic [1:0]  prio_port = 2'd0;

    t_result pending_status [$];
    int      mismatch_cnt = 0;
    int      reqs_sent = 0;
    int      send_idle_pct = 8;
    int      recv_idle_pct = 86;

    logic [7:0] stall_token = '0;
    logic [7:0] stall_ack = '0;
    int         hold_left = 0;

    function automatic t_result sniff_update(t_action act, logic [1:0] port_in,
                                             logic [7:0] b);
        int p;
        logic hit_ok;
        logic [2:0] hit;
        logic [1:0] prev;
        t_result r;
        p = (port_in >= NUM_PORTS) ? 0 : int'(port_in);
        hit_ok = 1'b0;
        hit = PROTO_UNKNOWN;
        case (act)
            ACT_DATA: begin
                seen[p] = 1'b1;
                if (phase_cnt[p] != COUNT_MAX) phase_cnt[p] = phase_cnt[p] + 1'b1;
                if (phase[p] != PH_IDLE && phase_cnt[p] > sync_limit) begin
                    phase[p] = PH_IDLE;
                    phase_cnt[p] = '0;
                end
                if (lock_cnt[p] >= lock_level) begin
                    // locked: keep reporting whatever was found
                    hit_ok = 1'b1;
                    hit = found[p];
                end else begin
                    prev = phase[p];
                    case (phase[p])
                        PH_IDLE: begin
                            if (b == mesh_a_first) begin
                                phase[p] = PH_MESH_A;
                            end else if (b == mesh_b_first) begin
                                phase[p] = PH_MESH_B;
                            end else if (b == fend_byte) begin
                                if (found[p] == PROTO_UNKNOWN || found[p] == PROTO_KISS) begin
                                    found[p] = PROTO_KISS;
                                    hit_ok = 1'b1;
                                    hit = PROTO_KISS;
                                end
                            end else if (b == CHAR_A) begin
                                phase[p] = PH_AT;
                            end
                        end
                        PH_MESH_A: begin
                            if (b == mesh_a_second) begin
                                found[p] = PROTO_MESH_A;
                                phase[p] = PH_IDLE;
                                hit_ok = 1'b1;
                                hit = PROTO_MESH_A;
                            end else if (b != mesh_a_first) begin
                                phase[p] = PH_IDLE;
                            end
                        end
                        PH_MESH_B: begin
                            if (b == mesh_b_second) begin
                                found[p] = PROTO_MESH_B;
                                hit_ok = 1'b1;
                                hit = PROTO_MESH_B;
                            end
                            phase[p] = PH_IDLE;
                        end
                        default: begin
                            if (b == CHAR_T) begin
                                found[p] = PROTO_AT;
                                hit_ok = 1'b1;
                                hit = PROTO_AT;
                            end
                            phase[p] = PH_IDLE;
                        end
                    endcase
                    // a completed detection leaves the byte count alone
                    if (!hit_ok && phase[p] != prev) phase_cnt[p] = '0;
                end
                if (hit_ok && (!prio_valid || prio_port == p || radio_owner == hit)) begin
                    if (radio_owner == PROTO_UNKNOWN || radio_owner == hit) radio_owner = hit;
                    if (!prio_valid && lock_cnt[p] >= lock_level) begin
                        prio_valid = 1'b1;
                        prio_port = p[1:0];
                    end
                end
            end
            ACT_CONFIRM: begin
                if (lock_cnt[p] != LOCK_MAX) lock_cnt[p] = lock_cnt[p] + 1'b1;
            end
            ACT_ERROR: begin
                lock_cnt[p] = (lock_cnt[p] > 8'd2) ? lock_cnt[p] - 8'd2 : 8'd0;
                if (lock_cnt[p] == 8'd0) found[p] = PROTO_UNKNOWN;
            end
            default: begin
                if (prio_valid && prio_port == p) begin
                    prio_valid = 1'b0;
                    prio_port = 2'd0;
                end
                phase[p] = PH_IDLE;
                found[p] = PROTO_UNKNOWN;
                lock_cnt[p] = '0;
                phase_cnt[p] = '0;
                seen[p] = 1'b0;
            end
        endcase
        r.port_protocol = found[p];
        r.port_locked = (lock_cnt[p] >= lock_level);
        r.radio_protocol = radio_owner;
        r.priority_valid = prio_valid;
        r.priority_port = prio_valid ? prio_port : 2'd0;
        r.active_ports = '0;
        for (int q = 0; q < NUM_PORTS; q++) r.active_ports[q] = seen[q];
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatch_cnt++;
    endtask

    task automatic check_status(logic [15:0] raw);
        t_result got;
        t_result want;
        got = t_result'(raw[$bits(t_result)-1:0]);
        if (pending_status.size() == 0) begin
            report_mismatch($sformatf("result 0x%04h with no request pending", raw));
        end else begin
            want = pending_status.pop_front();
            if (got.port_protocol != want.port_protocol)
                report_mismatch($sformatf("port_protocol got %0d want %0d",
                                          got.port_protocol, want.port_protocol));
            if (got.port_locked != want.port_locked)
                report_mismatch($sformatf("port_locked got %0d want %0d",
                                          got.port_locked, want.port_locked));
            if (got.radio_protocol != want.radio_protocol)
                report_mismatch($sformatf("radio_protocol got %0d want %0d",
                                          got.radio_protocol, want.radio_protocol));
            if (got.priority_valid != want.priority_valid)
                report_mismatch($sformatf("priority_valid got %0d want %0d",
                                          got.priority_valid, want.priority_valid));
            if (got.priority_port != want.priority_port)
                report_mismatch($sformatf("priority_port got %0d want %0d",
                                          got.priority_port, want.priority_port));
            if (got.active_ports != want.active_ports)
                report_mismatch($sformatf("active_ports got %b want %b",
                                          got.active_ports, want.active_ports));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) check_status(o_m_tdata);
    end

    // receiver: random stalls, plus a long hold-off whenever the token moves
    always @(posedge i_clk) begin
        if (stall_ack != stall_token) begin
            stall_ack <= stall_token;
            hold_left <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_req(t_action act, logic [1:0] port, logic [7:0] b);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= b;
        i_s_tuser <= {port, act};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pending_status.push_back(sniff_update(act, port, b));
        reqs_sent++;
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            REG_MESH_A_FIRST:  mesh_a_first = val[7:0];
            REG_MESH_A_SECOND: mesh_a_second = val[7:0];
            REG_MESH_B_FIRST:  mesh_b_first = val[7:0];
            REG_MESH_B_SECOND: mesh_b_second = val[7:0];
            REG_FRAME_END:     fend_byte = val[7:0];
            REG_SYNC_TIMEOUT:  sync_limit = val;
            REG_LOCK_LIMIT:    lock_level = val[7:0];
            default: ;
        endcase
    endtask

    task automatic load_config(logic [7:0] a1, logic [7:0] a2, logic [7:0] b1,
                               logic [7:0] b2, logic [7:0] fe, logic [15:0] tmo,
                               logic [7:0] lim);
        drain();
        write_reg(REG_MESH_A_FIRST, 16'(a1));
        write_reg(REG_MESH_A_SECOND, 16'(a2));
        write_reg(REG_MESH_B_FIRST, 16'(b1));
        write_reg(REG_MESH_B_SECOND, 16'(b2));
        write_reg(REG_FRAME_END, 16'(fe));
        write_reg(REG_SYNC_TIMEOUT, tmo);
        write_reg(REG_LOCK_LIMIT, 16'(lim));
        i_cfg_we <= 1'b0;
    endtask

    // mostly well-formed sync sequences on random ports, some broken ones and noise
    task automatic run_traffic(int n_items);
        int goal;
        int kind;
        int reps;
        logic [1:0] port;
        goal = reqs_sent + n_items;
        while (reqs_sent < goal) begin
            port = 2'($urandom_range(3));
            kind = $urandom_range(99);
            if (kind < 16) begin
                // repeated first bytes hold the phase and can run into the timeout
                reps = ($urandom_range(3) == 0) ? $urandom_range(10) : 0;
                send_req(ACT_DATA, port, mesh_a_first);
                repeat (reps) send_req(ACT_DATA, port, mesh_a_first);
                send_req(ACT_DATA, port, mesh_a_second);
            end else if (kind < 28) begin
                send_req(ACT_DATA, port, mesh_b_first);
                send_req(ACT_DATA, port, mesh_b_second);
            end else if (kind < 38) begin
                send_req(ACT_DATA, port, fend_byte);
            end else if (kind < 50) begin
                send_req(ACT_DATA, port, CHAR_A);
                send_req(ACT_DATA, port, CHAR_T);
            end else if (kind < 64) begin
                repeat ($urandom_range(1, 4))
                    send_req(ACT_CONFIRM, port, 8'($urandom_range(255)));
            end else if (kind < 72) begin
                send_req(ACT_ERROR, port, 8'($urandom_range(255)));
            end else if (kind < 77) begin
                send_req(ACT_RELEASE, port, 8'($urandom_range(255)));
            end else if (kind < 86) begin
                case ($urandom_range(2))
                    0: send_req(ACT_DATA, port, mesh_a_first);
                    1: send_req(ACT_DATA, port, mesh_b_first);
                    default: send_req(ACT_DATA, port, CHAR_A);
                endcase
                send_req(ACT_DATA, port, 8'($urandom_range(255)));
            end else begin
                send_req(ACT_DATA, port, 8'($urandom_range(255)));
            end
        end
    endtask

    task automatic test_directed();
        send_req(ACT_DATA, 2'd0, 8'd60);
        send_req(ACT_DATA, 2'd0, 8'd62);
        send_req(ACT_DATA, 2'd1, 8'd148);
        send_req(ACT_DATA, 2'd1, 8'd195);
        send_req(ACT_DATA, 2'd2, CHAR_A);
        send_req(ACT_DATA, 2'd2, CHAR_T);
        // port 3 maps onto port 0; frame end ignored with mesh A found
        send_req(ACT_DATA, 2'd3, 8'd192);
        repeat (3) send_req(ACT_CONFIRM, 2'd0, 8'hFF);
        send_req(ACT_DATA, 2'd0, 8'h00);
        send_req(ACT_DATA, 2'd0, 8'hFF);
        send_req(ACT_CONFIRM, 2'd1, 8'h00);
        send_req(ACT_ERROR, 2'd1, 8'h00);
        send_req(ACT_DATA, 2'd1, 8'd192);
        send_req(ACT_DATA, 2'd2, 8'd60);
        send_req(ACT_DATA, 2'd2, 8'd60);
        send_req(ACT_DATA, 2'd2, 8'd62);
        send_req(ACT_ERROR, 2'd3, 8'hAA);
        send_req(ACT_RELEASE, 2'd3, 8'h55);
        send_req(ACT_RELEASE, 2'd1, 8'h00);
        send_req(ACT_DATA, 2'd0, CHAR_A);
        send_req(ACT_DATA, 2'd0, 8'h58);
    endtask

    task automatic test_config_extremes();
        // all first bytes and frame end equal: first match in order wins
        load_config(CHAR_A, CHAR_T, CHAR_A, CHAR_T, CHAR_A, 16'd0, 8'd1);
        run_traffic(40);
        load_config(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 16'd65534, 8'd0);
        run_traffic(40);
        load_config(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 16'd1, 8'd255);
        run_traffic(40);
        load_config(8'd148, 8'd195, 8'd60, 8'd62, 8'd192, 16'd65534, 8'd1);
        run_traffic(40);
    endtask

    task automatic test_lock_saturation();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_config(8'd60, 8'd62, 8'd148, 8'd195, 8'd192, 16'd64, 8'd255);
        send_req(ACT_DATA, 2'd2, 8'd192);
        repeat (258) send_req(ACT_CONFIRM, 2'd2, 8'($urandom_range(255)));
        send_req(ACT_DATA, 2'd2, CHAR_A);
        send_req(ACT_ERROR, 2'd2, 8'h00);
        send_req(ACT_CONFIRM, 2'd2, 8'h00);
    endtask

    task automatic test_random(int s_pct, int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        load_config(($urandom_range(1) != 0) ? 8'd60 : 8'($urandom_range(255)),
                    ($urandom_range(1) != 0) ? 8'd62 : 8'($urandom_range(255)),
                    ($urandom_range(1) != 0) ? 8'd148 : 8'($urandom_range(255)),
                    ($urandom_range(1) != 0) ? 8'd195 : 8'($urandom_range(255)),
                    ($urandom_range(1) != 0) ? 8'd192 : 8'($urandom_range(255)),
                    ($urandom_range(3) == 0) ? 16'd64 : 16'($urandom_range(8)),
                    8'($urandom_range(4)));
        run_traffic(220);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_config(8'd60, 8'd62, 8'd148, 8'd195, 8'd192, 16'd4, 8'd2);
        stall_token <= stall_token + 1'b1;
        run_traffic(40);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_config_extremes();
        test_random(8, 86);
        test_random(86, 8);
        test_random(0, 0);
        test_lock_saturation();
        test_backpressure();
        drain();
        if (mismatch_cnt == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
